@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

@@ rtl/ufp_pkg.sv @@
// Package with the constants, types and helper functions of the range frame parser.
`timescale 1ns / 1ps
package ufp_pkg;

    localparam int LINE_DEPTH = 16;
    localparam int PosW       = $clog2(LINE_DEPTH);
    localparam int FrameLen   = 6;
    localparam int FieldLen   = 5;
    localparam int SlotW      = $clog2(FrameLen);
    localparam int IdxW       = $clog2(FieldLen);

    localparam int ByteW = 8;
    localparam int ChanW = 3;
    localparam int MmW   = 18;
    localparam int InW   = 21;
    localparam int ValW  = 17;
    localparam int NumW  = 27;
    localparam int RecW  = 28;
    localparam int ProdW = NumW + RecW;
    localparam int RecipShift = 34;
    localparam logic [RecW-1:0] RecipM =
        RecW'(((64'd1 << RecipShift) + 64'd126) / 64'd127);

    localparam logic [ByteW-1:0] ChrCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChrTab   = 8'h09;
    localparam logic [ByteW-1:0] ChrLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChrSpace = 8'h20;
    localparam logic [ByteW-1:0] ChrPlus  = 8'h2B;
    localparam logic [ByteW-1:0] ChrMinus = 8'h2D;
    localparam logic [ByteW-1:0] Chr0     = 8'h30;
    localparam logic [ByteW-1:0] Chr9     = 8'h39;
    localparam logic [ByteW-1:0] ChrA     = 8'h41;
    localparam logic [ByteW-1:0] ChrF     = 8'h46;

    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [ChanW-1:0]               channel;
        logic [FieldLen-1:0][ByteW-1:0] chars;
    } t_frame;

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == ChrSpace) || ((c >= ChrTab) && (c <= ChrCr));
    endfunction

    function automatic logic is_digit(input logic [ByteW-1:0] c);
        return (c >= Chr0) && (c <= Chr9);
    endfunction

endpackage

@@ rtl/ufp_if.sv @@
// Channel interfaces for received bytes and parsed range results.
`timescale 1ns / 1ps
interface ufp_byte_if;
    import ufp_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufp_result_if;
    import ufp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ChanW-1:0]        channel;
    logic signed [MmW-1:0]   distance_mm;
    logic signed [InW-1:0]   distance_inches_q8;
    modport source (output valid, output channel, output distance_mm,
                    output distance_inches_q8, input ready);
    modport sink (input valid, input channel, input distance_mm,
                  input distance_inches_q8, output ready);
endinterface

@@ rtl/ufp_front.sv @@
// Front end: takes bytes, tracks the line position and detects complete frames.
`timescale 1ns / 1ps
module ufp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ufp_byte_if.sink        i_rx,
    input  logic            i_full,
    output logic            o_push,
    output ufp_pkg::t_frame o_frame
);
    import ufp_pkg::*;

    logic [PosW-1:0]  r_pos;
    logic [PosW-1:0]  n_pos;
    logic [ByteW-1:0] r_slot [FrameLen];
    logic             accept;
    logic             is_term;
    logic             lead_ok;
    logic [ByteW-1:0] lead_off;

    assign i_rx.ready = !i_full;
    assign accept     = i_rx.valid && !i_full;
    assign is_term    = (i_rx.rx_byte == ChrCr) || (i_rx.rx_byte == ChrTab);
    assign lead_ok    = (r_slot[0] >= ChrA) && (r_slot[0] <= ChrF);
    assign lead_off   = r_slot[0] - ChrA;
    assign o_push     = accept && is_term && (r_pos == PosW'(FrameLen)) && lead_ok;

    always_comb begin
        o_frame.channel = lead_off[ChanW-1:0];
        for (int k = 0; k < FieldLen; k++) begin
            o_frame.chars[k] = r_slot[k + 1];
        end
    end

    always_comb begin
        if (is_term) begin
            n_pos = '0;
        end else if (r_pos == PosW'(LINE_DEPTH - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + PosW'(1);
        end
    end

    // Only the first slots of a line can ever form a frame, so only they are kept.
    always_ff @(posedge i_clk) begin
        if (accept && !is_term && (r_pos < PosW'(FrameLen))) begin
            r_slot[r_pos[SlotW-1:0]] <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

@@ rtl/ufp_queue.sv @@
// Two-entry frame queue between the front end and the number parser.
`timescale 1ns / 1ps
module ufp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ufp_pkg::t_frame i_frame,
    output logic            o_full,
    output logic            o_valid,
    output ufp_pkg::t_frame o_frame,
    input  logic            i_pop
);
    import ufp_pkg::*;

    t_frame           r_mem [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QCntW-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCntW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCntW'(1);
            end
        end
    end

endmodule

@@ rtl/ufp_back.sv @@
// Back end: parses the distance field one character a cycle and scales it to inches.
`timescale 1ns / 1ps
module ufp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ufp_pkg::t_frame i_frame,
    output logic            o_ready,
    ufp_result_if.source    o_res
);
    import ufp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PARSE, S_NUM, S_MUL, S_OUT} t_state;
    typedef enum logic [1:0] {PH_BLANK, PH_DIGIT, PH_STOP} t_phase;

    t_state                         r_state;
    t_phase                         r_phase;
    t_phase                         n_phase;
    logic [IdxW-1:0]                r_idx;
    logic [FieldLen-1:0][ByteW-1:0] r_chars;
    logic [ChanW-1:0]               r_chan;
    logic                           r_neg;
    logic                           n_neg;
    logic [ValW-1:0]                r_val;
    logic [ValW-1:0]                n_val;
    logic [NumW-1:0]                r_num;
    logic [ProdW-1:0]               r_prod;
    logic                           r_out_valid;
    logic [ChanW-1:0]               r_out_chan;
    logic signed [MmW-1:0]          r_out_mm;
    logic signed [InW-1:0]          r_out_in;

    logic [ByteW-1:0] cur;
    logic [ByteW-1:0] dig_full;
    logic [ValW-1:0]  dig;
    logic [RecW-1:0]  scaled;
    logic [InW-1:0]   quot;
    logic             out_free;

    assign cur      = r_chars[0];
    assign dig_full = cur - Chr0;
    assign dig      = ValW'(dig_full[3:0]);
    assign scaled   = (RecW'(r_val) << 11) + (RecW'(r_val) << 9) + RecW'(127);
    assign quot     = r_prod[ProdW-1:RecipShift];
    assign out_free = !r_out_valid || o_res.ready;
    assign o_ready  = (r_state == S_IDLE);

    assign o_res.valid              = r_out_valid;
    assign o_res.channel            = r_out_chan;
    assign o_res.distance_mm        = r_out_mm;
    assign o_res.distance_inches_q8 = r_out_in;

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_val   = r_val;
        case (r_phase)
            PH_BLANK: begin
                if (is_blank(cur)) begin
                    n_phase = PH_BLANK;
                end else if ((cur == ChrPlus) || (cur == ChrMinus)) begin
                    n_neg   = (cur == ChrMinus);
                    n_phase = PH_DIGIT;
                end else if (is_digit(cur)) begin
                    n_val   = dig;
                    n_phase = PH_DIGIT;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_DIGIT: begin
                if (is_digit(cur)) begin
                    n_val = (r_val << 3) + (r_val << 1) + dig;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && !((r_state == S_OUT) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_chars <= i_frame.chars;
                        r_chan  <= i_frame.channel;
                        r_phase <= PH_BLANK;
                        r_neg   <= 1'b0;
                        r_val   <= '0;
                        r_idx   <= '0;
                        r_state <= S_PARSE;
                    end
                end
                S_PARSE: begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_val   <= n_val;
                    r_chars <= {ByteW'(0), r_chars[FieldLen-1:1]};
                    r_idx   <= r_idx + IdxW'(1);
                    if (r_idx == IdxW'(FieldLen - 1)) begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_num   <= scaled[RecW-1:1];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= ProdW'(r_num) * ProdW'(RecipM);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_chan  <= r_chan;
                        r_out_mm    <= r_neg ? -MmW'(r_val) : MmW'(r_val);
                        r_out_in    <= r_neg ? -quot : quot;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/ultrasonic_range_frame_parser.sv @@
// Top level of the ultrasonic range frame parser.
//
// The i_rx channel carries one received serial byte per beat; the o_res channel
// carries one parsed range per beat: sensor channel, distance in millimeters and
// distance in inches as signed Q.8. Both use valid/ready handshakes.
// A carriage return or tab ends a line; the line position wraps at 16 bytes. A
// line whose length modulo 16 is six and whose sixth-last byte is a letter A to
// F produces one result; every other line produces none.
// Bytes are taken one per cycle while the frame queue has room. The terminator
// beat writes the frame queue; the parser then pops the frame, runs the
// character-by-character number parser over its five characters, then the
// scaling add, the reciprocal multiply and the output register. The parser
// handles one frame at a time and takes no new frame before the last is done.
// A two-entry frame queue sits between byte intake and the parser; when it is
// full, i_rx.ready drops. When the receiver stalls, the result stays in the
// output register and the parser holds its finished frame until it frees up.
// Reset clears the line position, the queue and the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ultrasonic_range_frame_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ufp_byte_if.sink     i_rx,
    ufp_result_if.source o_res
);
    import ufp_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_frame q_in;
    t_frame q_out;

    ufp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_frame (q_in)
    );

    ufp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_frame (q_out),
        .i_pop   (q_pop)
    );

    ufp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_frame (q_out),
        .o_ready (q_pop),
        .o_res   (o_res)
    );

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, q_push && q_full, "frame queue overflow")
    `ASSERT_CLK(a_channel_range, i_clk, i_rst_n, o_res.valid |-> (o_res.channel <= ChanW'(5)), "channel out of range")
    `ASSERT_CLK(a_mm_range, i_clk, i_rst_n, o_res.valid |-> ((o_res.distance_mm <= 18'sd99999) && (o_res.distance_mm >= -18'sd99999)), "distance out of range")
    `ASSERT_CLK(a_sign_match, i_clk, i_rst_n, o_res.valid |-> (o_res.distance_mm[MmW-1] == o_res.distance_inches_q8[InW-1]), "inch sign differs from millimeter sign")

endmodule

@@ bench/ultrasonic_range_frame_parser_tb.sv @@
// Testbench for the range frame parser: serial bytes in, checked range results out.
`timescale 1ns / 1ps
module ultrasonic_range_frame_parser_tb;
    import ufp_pkg::*;

    localparam logic [ByteW-1:0] ChrVt = 8'h0B;
    localparam logic [ByteW-1:0] ChrFf = 8'h0C;

    class range_scoreboard;
        typedef struct {
            logic [ChanW-1:0]      channel;
            logic signed [MmW-1:0] mm;
            logic signed [InW-1:0] inch_q8;
        } t_range;

        logic [ByteW-1:0] line_buf [LINE_DEPTH];
        int               wr_pos;
        t_range           pending_q [$];
        int               errors;
        int               checked;
        int               frames;

        function new();
            foreach (line_buf[i]) line_buf[i] = '0;
            wr_pos  = 0;
            errors  = 0;
            checked = 0;
            frames  = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Reads the five characters after the letter the way strtol does in base ten.
        function int parse_mm();
            int i;
            bit neg;
            int val;
            i   = 1;
            neg = 1'b0;
            val = 0;
            while (i < FrameLen && (line_buf[i] == ChrSpace ||
                   (line_buf[i] >= ChrTab && line_buf[i] <= ChrCr)))
                i++;
            if (i < FrameLen && (line_buf[i] == ChrPlus || line_buf[i] == ChrMinus)) begin
                neg = (line_buf[i] == ChrMinus);
                i++;
            end
            while (i < FrameLen && line_buf[i] >= Chr0 && line_buf[i] <= Chr9) begin
                val = val * 10 + int'(line_buf[i] - Chr0);
                i++;
            end
            return neg ? -val : val;
        endfunction

        function void note_byte(logic [ByteW-1:0] b);
            t_range      r;
            int          pos;
            int          mm;
            int unsigned mag;
            int unsigned q;
            pos = wr_pos;
            if (b != ChrCr && b != ChrTab) begin
                line_buf[pos] = b;
                wr_pos = (pos == LINE_DEPTH - 1) ? 0 : pos + 1;
                return;
            end
            line_buf[pos] = '0;
            wr_pos = 0;
            if (pos != FrameLen || line_buf[0] < ChrA || line_buf[0] > ChrF)
                return;
            mm  = parse_mm();
            mag = (mm < 0) ? -mm : mm;
            // Inches in Q.8 are mm * 256 / 25.4, rounded half away from zero.
            q = (mag * 2560 + 127) / 254;
            r.channel = ChanW'(line_buf[0] - ChrA);
            r.mm      = MmW'(mm);
            r.inch_q8 = InW'((mm < 0) ? -int'(q) : int'(q));
            pending_q.push_back(r);
            frames++;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_result(logic [ChanW-1:0] ch, logic signed [MmW-1:0] mm,
                          logic signed [InW-1:0] inch);
            t_range e;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result with none expected: ch=%0d mm=%0d in=%0d",
                                          ch, mm, inch));
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (ch !== e.channel || mm !== e.mm || inch !== e.inch_q8)
                report_mismatch($sformatf("got ch=%0d mm=%0d in=%0d, want ch=%0d mm=%0d in=%0d",
                                          ch, mm, inch, e.channel, e.mm, e.inch_q8));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle;
    int   snk_idle;
    int   bytes_sent;
    int   target;

    range_scoreboard sb;

    ufp_byte_if   rx_if ();
    ufp_result_if res_if ();

    ultrasonic_range_frame_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_result(res_if.channel, res_if.distance_mm, res_if.distance_inches_q8);
    end

    task automatic send_byte(logic [ByteW-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(ByteW'(s[i]));
    endtask

    task automatic drain();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ByteW-1:0] pick_blank();
        case ($urandom_range(3))
            0:       return ChrSpace;
            1:       return ChrLf;
            2:       return ChrVt;
            default: return ChrFf;
        endcase
    endfunction

    // Mostly well-formed frames with random content, the rest broken lines and noise.
    task automatic send_random_line();
        int               kind;
        int               len;
        int               nblank;
        bit               structured;
        bit               has_sign;
        logic [ByteW-1:0] b;
        kind = $urandom_range(99);
        if (kind < 15) begin
            len = $urandom_range(1, 40);
            repeat (len) send_byte(ByteW'($urandom_range(255)));
            return;
        end
        if (kind < 80) begin
            len = FieldLen;
        end else begin
            len = $urandom_range(0, 13);
            if (len >= FieldLen) len++;
        end
        if ($urandom_range(9) == 0) b = ByteW'($urandom_range(255));
        else b = ChrA + ByteW'($urandom_range(5));
        send_byte(b);
        structured = 1'($urandom_range(1));
        nblank     = $urandom_range(0, 3);
        has_sign   = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
            if (structured) begin
                if (i < nblank) b = pick_blank();
                else if (i == nblank && has_sign) b = $urandom_range(1) ? ChrMinus : ChrPlus;
                else if ($urandom_range(9) == 0) b = ByteW'($urandom_range(255));
                else b = Chr0 + ByteW'($urandom_range(9));
            end else begin
                case ($urandom_range(4))
                    0:       b = pick_blank();
                    1:       b = $urandom_range(1) ? ChrMinus : ChrPlus;
                    2:       b = ByteW'($urandom_range(255));
                    default: b = Chr0 + ByteW'($urandom_range(9));
                endcase
            end
            send_byte(b);
        end
        send_byte($urandom_range(1) ? ChrCr : ChrTab);
    endtask

    initial begin
        sb = new();
        bytes_sent = 0;
        src_idle   = 33;
        snk_idle   = 73;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_text("A12345"); send_byte(ChrCr);
        send_text("F99999"); send_byte(ChrTab);
        send_text("B-9999"); send_byte(ChrCr);
        send_text("C+0001"); send_byte(ChrTab);
        send_text("A-0001"); send_byte(ChrCr);
        send_text("D   42"); send_byte(ChrCr);
        send_text("E"); send_byte(ChrLf); send_byte(ChrVt); send_byte(ChrFf);
        send_text("-7"); send_byte(ChrTab);
        send_text("A +-5"); send_byte(ChrCr);
        send_text("B12x45"); send_byte(ChrTab);
        send_text("C     "); send_byte(ChrCr);
        send_text("D-    "); send_byte(ChrCr);
        send_text("E 0 99"); send_byte(ChrCr);
        send_text("F00000"); send_byte(ChrTab);
        send_text("A5"); send_byte(8'h00); send_byte(8'hFF); send_text("9"); send_byte(ChrCr);
        send_text("G12345"); send_byte(ChrCr);
        send_text("@12345"); send_byte(ChrTab);
        send_text("A1234"); send_byte(ChrCr);
        send_text("A123456"); send_byte(ChrCr);
        send_byte(ChrCr);
        send_byte(ChrTab);
        // A line longer than the buffer wraps, so the last six bytes form the frame.
        repeat (LINE_DEPTH) send_byte(8'hAA);
        send_text("E00127"); send_byte(ChrCr);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle = 33;
                    snk_idle = 73;
                end
                1: begin
                    src_idle = 73;
                    snk_idle = 33;
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            target = bytes_sent + 380;
            while (bytes_sent < target) send_random_line();
            drain();
        end
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d range results under three stall mixes.",
                 bytes_sent, sb.checked);
        $display("Lines covered signs, blanks, junk, wrong lengths, bad letters and wrap.");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
